// File: rtl/mpq_pkg.sv
// shared types, constants and codes of the multilevel priority ready queue
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int NUM_LEVELS_DEF  = 8;
    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int NUM_TASKS_DEF   = 16;

    localparam int TASK_W   = 4;
    localparam int PRIO_W   = 3;
    localparam int PC_W     = 16;
    localparam int ORDER_W  = 8;
    localparam int STATUS_W = 3;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [STATUS_W-1:0] {
        STAT_PUSHED  = 3'd0,
        STAT_DROPPED = 3'd1,
        STAT_POPPED  = 3'd2,
        STAT_IDLE    = 3'd3,
        STAT_NONE    = 3'd4
    } status_t;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_WORK = 1'b1
    } fsm_t;

    typedef struct packed {
        logic sel_pop;
        logic push;
        logic pop;
    } lvl_cmd_t;

    typedef struct packed {
        logic any_ready;
        logic full;
    } lvl_stat_t;

    typedef struct packed {
        logic [TASK_W-1:0]  task_id;
        logic [ORDER_W-1:0] order;
        logic [PC_W-1:0]    pc;
    } entry_t;

endpackage

// File: rtl/mpq_entry_mem.sv
// entry memory: task id, stamp and resume address of every queued slot
`timescale 1ns / 1ps

module mpq_entry_mem #(
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  mpq_pkg::entry_t  wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output mpq_pkg::entry_t  rd_data
);
    import mpq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/mpq_stamp_mem.sv
// per-task activation count memory, entries read as zero until written
`timescale 1ns / 1ps

module mpq_stamp_mem #(
    parameter int NUM_TASKS = 16,
    localparam int TW       = $clog2(NUM_TASKS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [TW-1:0]               rd_addr,
    output logic [mpq_pkg::ORDER_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [TW-1:0]               wr_addr,
    input  logic [mpq_pkg::ORDER_W-1:0] wr_data
);
    import mpq_pkg::*;

    logic [ORDER_W-1:0]   mem [NUM_TASKS];
    logic [ORDER_W-1:0]   rd_q_reg;
    logic [NUM_TASKS-1:0] valid_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

// File: rtl/mpq_level_ctrl.sv
// per-level fifo pointers, fill counts and highest ready level search
`timescale 1ns / 1ps

module mpq_level_ctrl #(
    parameter int NUM_LEVELS  = 8,
    parameter int LEVEL_DEPTH = 16,
    localparam int LW         = $clog2(NUM_LEVELS),
    localparam int PW         = $clog2(LEVEL_DEPTH),
    localparam int CW         = $clog2(LEVEL_DEPTH + 1),
    localparam int SW         = $clog2(NUM_LEVELS * LEVEL_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mpq_pkg::lvl_cmd_t   cmd,
    input  logic [LW-1:0]       push_level,
    output logic [LW-1:0]       pop_level,
    output logic [SW-1:0]       slot,
    output mpq_pkg::lvl_stat_t  stat
);
    import mpq_pkg::*;

    logic [PW-1:0]         head_reg  [NUM_LEVELS];
    logic [PW-1:0]         tail_reg  [NUM_LEVELS];
    logic [CW-1:0]         count_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] ready_reg;

    logic [LW-1:0] sel_level;
    logic [PW-1:0] sel_ptr;
    logic [PW-1:0] ptr_inc;
    logic [CW-1:0] sel_count;

    // highest non-empty level
    always_comb
    begin
        pop_level = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (ready_reg[i])
            begin
                pop_level = LW'(i);
            end
        end
    end

    assign sel_level = cmd.sel_pop ? pop_level : push_level;
    assign sel_ptr   = cmd.sel_pop ? head_reg[sel_level] : tail_reg[sel_level];
    assign sel_count = count_reg[sel_level];
    assign ptr_inc   = (sel_ptr == PW'(LEVEL_DEPTH - 1)) ? '0 : PW'(sel_ptr + 1'b1);

    assign slot = SW'(SW'(sel_level) * SW'(LEVEL_DEPTH) + SW'(sel_ptr));

    assign stat.any_ready = |ready_reg;
    assign stat.full      = (sel_count == CW'(LEVEL_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            ready_reg <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                tail_reg[sel_level]  <= ptr_inc;
                count_reg[sel_level] <= CW'(sel_count + 1'b1);
                ready_reg[sel_level] <= 1'b1;
            end
            else if (cmd.pop)
            begin
                head_reg[sel_level]  <= ptr_inc;
                count_reg[sel_level] <= CW'(sel_count - 1'b1);
                if (sel_count == CW'(1))
                begin
                    ready_reg[sel_level] <= 1'b0;
                end
            end
        end
    end

    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> sel_count != '0)
        else $error("pop from a level whose fill count is zero");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> sel_count != CW'(LEVEL_DEPTH))
        else $error("push into a full level");

    a_ready_tracks_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop && sel_count == CW'(1)) |=> !ready_reg[$past(sel_level)])
        else $error("level still marked ready after its last entry left");

endmodule

// File: rtl/multilevel_priority_ready_queue_top.sv
// top level of the multilevel priority ready queue
`timescale 1ns / 1ps

// Ready queue with one circular fifo per priority level. A push word stores
// task id and resume address at the tail of its level and stamps it with the
// task's activation count (wraps at 256); a push to a full or out-of-range
// level, or with an out-of-range task, is dropped with status 1. A pop word
// returns the oldest entry of the highest non-empty level, or the idle answer
// (status 3) or no task (status 4) when empty. The entry and activation-count
// memories are read in the cycle a word is accepted and the result is formed
// and written back in the next; no new word is accepted until the last one
// is through. No clearing pass after reset.
module multilevel_priority_ready_queue_top #(
    parameter int NUM_LEVELS  = mpq_pkg::NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH = mpq_pkg::LEVEL_DEPTH_DEF,
    parameter int NUM_TASKS   = mpq_pkg::NUM_TASKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // task_id, priority_req, task_pc_in, some_sleeping
    input  logic [mpq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_task, out_priority, out_order, out_pc, zero pad
    output logic [mpq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [mpq_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import mpq_pkg::*;

    localparam int LW = $clog2(NUM_LEVELS);
    localparam int TW = $clog2(NUM_TASKS);
    localparam int SW = $clog2(NUM_LEVELS * LEVEL_DEPTH);

    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] priority_req;
    logic [PC_W-1:0]   task_pc_in;
    logic              some_sleeping;
    req_t              req_type;

    fsm_t state_reg;
    fsm_t state_next;

    logic s_accept;
    logic work;
    logic tid_ok;
    logic lvl_ok;
    logic push_ok;

    lvl_cmd_t  lvl_cmd;
    lvl_stat_t lvl_stat;
    logic [LW-1:0] push_level;
    logic [LW-1:0] pop_level;
    logic [SW-1:0] slot;

    status_t           kind_next;
    status_t           kind_reg;
    logic [LW-1:0]     level_reg;
    logic [TASK_W-1:0] task_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [SW-1:0]     slot_reg;

    entry_t             entry_rd;
    entry_t             entry_wr;
    logic               commit_push;
    logic [ORDER_W-1:0] stamp_rd;
    logic [ORDER_W-1:0] stamp_new;

    logic               m_valid_reg;
    status_t            out_status_reg;
    logic [TASK_W-1:0]  out_task_reg;
    logic [PRIO_W-1:0]  out_priority_reg;
    logic [ORDER_W-1:0] out_order_reg;
    logic [PC_W-1:0]    out_pc_reg;

    assign task_id       = s_axis_tdata[3:0];
    assign priority_req  = s_axis_tdata[6:4];
    assign task_pc_in    = s_axis_tdata[22:7];
    assign some_sleeping = s_axis_tdata[23];
    assign req_type      = req_t'(s_axis_tuser);

    assign s_accept   = s_axis_tvalid && s_axis_tready;
    assign tid_ok     = 32'(task_id) < 32'(NUM_TASKS);
    assign lvl_ok     = 32'(priority_req) < 32'(NUM_LEVELS);
    assign push_level = LW'(priority_req);
    assign push_ok    = tid_ok && lvl_ok && !lvl_stat.full;

    assign lvl_cmd.sel_pop = (req_type == REQ_POP);
    assign lvl_cmd.push    = s_accept && (req_type == REQ_PUSH) && push_ok;
    assign lvl_cmd.pop     = s_accept && (req_type == REQ_POP) && lvl_stat.any_ready;

    always_comb
    begin
        priority if (req_type == REQ_POP)
        begin
            priority if (lvl_stat.any_ready)
            begin
                kind_next = STAT_POPPED;
            end
            else if (some_sleeping)
            begin
                kind_next = STAT_IDLE;
            end
            else
            begin
                kind_next = STAT_NONE;
            end
        end
        else if (push_ok)
        begin
            kind_next = STAT_PUSHED;
        end
        else
        begin
            kind_next = STAT_DROPPED;
        end
    end

    // state machine
    always_comb
    begin
        unique case (state_reg)
            FSM_IDLE: state_next = s_accept ? FSM_WORK : FSM_IDLE;
            FSM_WORK: state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            FSM_IDLE:
            begin
                s_axis_tready = !m_valid_reg || m_axis_tready;
                work          = 1'b0;
            end
            FSM_WORK:
            begin
                s_axis_tready = 1'b0;
                work          = 1'b1;
            end
            default:
            begin
                s_axis_tready = 1'b0;
                work          = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            kind_reg  <= STAT_NONE;
        end
        else
        begin
            state_reg <= state_next;
            if (s_accept)
            begin
                kind_reg <= kind_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            level_reg <= pop_level;
            task_reg  <= task_id;
            pc_reg    <= task_pc_in;
            slot_reg  <= slot;
        end
    end

    mpq_level_ctrl #(
        .NUM_LEVELS  (NUM_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_level_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (lvl_cmd),
        .push_level (push_level),
        .pop_level  (pop_level),
        .slot       (slot),
        .stat       (lvl_stat)
    );

    // write-back of a push in the cycle after acceptance
    assign commit_push = work && (kind_reg == STAT_PUSHED);
    assign stamp_new   = ORDER_W'(stamp_rd + 1'b1);

    assign entry_wr.task_id = task_reg;
    assign entry_wr.order   = stamp_new;
    assign entry_wr.pc      = pc_reg;

    mpq_entry_mem #(
        .DEPTH (NUM_LEVELS * LEVEL_DEPTH)
    ) u_entry_mem (
        .clk     (clk),
        .wr_en   (commit_push),
        .wr_addr (slot_reg),
        .wr_data (entry_wr),
        .rd_en   (lvl_cmd.pop),
        .rd_addr (slot),
        .rd_data (entry_rd)
    );

    mpq_stamp_mem #(
        .NUM_TASKS (NUM_TASKS)
    ) u_stamp_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (lvl_cmd.push),
        .rd_addr (TW'(task_id)),
        .rd_data (stamp_rd),
        .wr_en   (commit_push),
        .wr_addr (TW'(task_reg)),
        .wr_data (stamp_new)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (work)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work)
        begin
            out_status_reg <= kind_reg;
            if (kind_reg == STAT_POPPED)
            begin
                out_task_reg     <= entry_rd.task_id;
                out_priority_reg <= PRIO_W'(level_reg);
                out_order_reg    <= entry_rd.order;
                out_pc_reg       <= entry_rd.pc;
            end
            else
            begin
                out_task_reg     <= '0;
                out_priority_reg <= '0;
                out_order_reg    <= '0;
                out_pc_reg       <= '0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {1'b0, out_pc_reg, out_order_reg, out_priority_reg, out_task_reg};

    a_accept_blocks_next: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_axis_tready)
        else $error("word accepted while the previous one is still in work");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == FSM_WORK))
        else $error("result appeared without a work cycle");

    a_work_finds_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !(m_valid_reg && !$past(work)))
        else $error("output register still busy when a result is due");

endmodule

// File: sim/multilevel_priority_ready_queue_top_test.sv
// self-checking testbench of the multilevel priority ready queue top level
`timescale 1ns / 1ps

module multilevel_priority_ready_queue_top_test;

    import mpq_pkg::*;

    localparam int NUM_LEVELS     = NUM_LEVELS_DEF;
    localparam int LEVEL_DEPTH    = LEVEL_DEPTH_DEF;
    localparam int NUM_TASKS      = NUM_TASKS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        status_t             st;
        logic [PC_W-1:0]     pc;
        logic [ORDER_W-1:0]  order;
        logic [PRIO_W-1:0]   lvl;
        logic [TASK_W-1:0]   tid;
    } ready_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // task_id, priority_req, task_pc_in, some_sleeping
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // req_type
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // out_task, out_priority, out_order, out_pc, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // status
    logic [STATUS_W-1:0]   m_axis_tuser;

    multilevel_priority_ready_queue_top #(
        .NUM_LEVELS  (NUM_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .NUM_TASKS   (NUM_TASKS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow of the ready queue
    logic [TASK_W-1:0]  slot_task  [NUM_LEVELS*LEVEL_DEPTH];
    logic [PC_W-1:0]    slot_pc    [NUM_LEVELS*LEVEL_DEPTH];
    logic [ORDER_W-1:0] slot_order [NUM_LEVELS*LEVEL_DEPTH];
    int                 lvl_head   [NUM_LEVELS] = '{default: 0};
    int                 lvl_tail   [NUM_LEVELS] = '{default: 0};
    int                 lvl_fill   [NUM_LEVELS] = '{default: 0};
    logic [ORDER_W-1:0] act_count  [NUM_TASKS]  = '{default: '0};
    int                 queued_total = 0;
    int                 top_lvl = 0;

    ready_result_t expected_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int errors = 0;
    int words_sent = 0;
    int results_checked = 0;
    int pop_count = 0;
    int drop_count = 0;
    int empty_count = 0;
    int hot_lvl = 0;
    int push_pct = 50;

    ready_result_t got;
    ready_result_t want;

    function automatic ready_result_t ready_queue_step(req_t req, logic [TASK_W-1:0] tid,
                                                       logic [PRIO_W-1:0] lvl,
                                                       logic [PC_W-1:0] pc, logic sleep);
        ready_result_t r;
        int lv;
        int slot;
        r = '0;
        if (req == REQ_PUSH)
        begin
            lv = int'(lvl);
            if (tid >= NUM_TASKS || lv >= NUM_LEVELS || lvl_fill[lv] >= LEVEL_DEPTH)
            begin
                r.st = STAT_DROPPED;
            end
            else
            begin
                slot = lv * LEVEL_DEPTH + lvl_tail[lv];
                act_count[tid] = act_count[tid] + 1'b1;
                slot_task[slot] = tid;
                slot_pc[slot] = pc;
                slot_order[slot] = act_count[tid];
                lvl_tail[lv] = (lvl_tail[lv] + 1) % LEVEL_DEPTH;
                lvl_fill[lv]++;
                queued_total++;
                if (lv > top_lvl)
                    top_lvl = lv;
                r.st = STAT_PUSHED;
            end
        end
        else if (queued_total == 0)
        begin
            r.st = sleep ? STAT_IDLE : STAT_NONE;
        end
        else
        begin
            lv = top_lvl;
            while (lvl_fill[lv] == 0 && lv != 0)
                lv--;
            slot = lv * LEVEL_DEPTH + lvl_head[lv];
            r.st = STAT_POPPED;
            r.tid = slot_task[slot];
            r.lvl = lv[PRIO_W-1:0];
            r.order = slot_order[slot];
            r.pc = slot_pc[slot];
            lvl_head[lv] = (lvl_head[lv] + 1) % LEVEL_DEPTH;
            lvl_fill[lv]--;
            queued_total--;
            while (lvl_fill[lv] == 0 && lv != 0)
                lv--;
            top_lvl = lv;
        end
        return r;
    endfunction

    task automatic send_word(req_t req, logic [TASK_W-1:0] tid, logic [PRIO_W-1:0] lvl,
                             logic [PC_W-1:0] pc, logic sleep);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {sleep, pc, lvl, tid};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(ready_queue_step(req, tid, lvl, pc, sleep));
        words_sent++;
    endtask

    task automatic send_random_word();
        req_t req;
        logic [PRIO_W-1:0] lvl;
        req = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
        lvl = ($urandom_range(3) != 0) ? hot_lvl[PRIO_W-1:0]
                                       : PRIO_W'($urandom_range(NUM_LEVELS - 1));
        send_word(req, TASK_W'($urandom_range(NUM_TASKS - 1)), lvl,
                  PC_W'($urandom_range(16'hffff)), 1'($urandom_range(1)));
    endtask

    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_edges();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_word(REQ_POP, 4'd0, 3'd0, 16'h0000, 1'b0);
        send_word(REQ_POP, 4'd15, 3'd7, 16'hffff, 1'b1);
        send_word(REQ_PUSH, 4'd15, 3'd0, 16'hffff, 1'b1);
        send_word(REQ_PUSH, 4'd0, 3'd7, 16'h0000, 1'b0);
        send_word(REQ_PUSH, 4'd5, 3'd3, 16'h1234, 1'b0);
        send_word(REQ_PUSH, 4'd15, 3'd7, 16'haaaa, 1'b1);
        repeat (4)
            send_word(REQ_POP, 4'd0, 3'd0, 16'h5555, 1'b0);
        send_word(REQ_POP, 4'd0, 3'd0, 16'h0000, 1'b1);
        finish_phase();
    endtask

    task automatic test_level_full();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (LEVEL_DEPTH + 2)
            send_word(REQ_PUSH, TASK_W'($urandom_range(NUM_TASKS - 1)), 3'd5,
                      PC_W'($urandom_range(16'hffff)), 1'($urandom_range(1)));
        repeat (LEVEL_DEPTH + 1)
            send_word(REQ_POP, 4'd0, 3'd0, 16'h0000, 1'($urandom_range(1)));
        finish_phase();
    endtask

    task automatic test_random_mix(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
        begin
            if (i % 30 == 0)
            begin
                push_pct = $urandom_range(30, 80);
                hot_lvl = $urandom_range(NUM_LEVELS - 1);
            end
            send_random_word();
        end
        finish_phase();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        push_pct = 70;
        hold_request = 150;
        repeat (40)
            send_random_word();
        finish_phase();
    endtask

    // result check and receiver ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.st = status_t'(m_axis_tuser);
                got.pc = m_axis_tdata[30:15];
                got.order = m_axis_tdata[14:7];
                got.lvl = m_axis_tdata[6:4];
                got.tid = m_axis_tdata[3:0];
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected result word: status=%0d data=%h",
                                 m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    case (want.st)
                        STAT_POPPED:  pop_count++;
                        STAT_DROPPED: drop_count++;
                        STAT_IDLE,
                        STAT_NONE:    empty_count++;
                        default: ;
                    endcase
                    if (got !== want || m_axis_tdata[OUT_DATA_W-1] !== 1'b0)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("mismatch: expected st=%0d task=%0d lvl=%0d ord=%0d pc=%h",
                                     want.st, want.tid, want.lvl, want.order, want.pc);
                            $display("          got st=%0d task=%0d lvl=%0d ord=%0d pc=%h pad=%b",
                                     got.st, got.tid, got.lvl, got.order, got.pc,
                                     m_axis_tdata[OUT_DATA_W-1]);
                        end
                    end
                end
            end
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_level_full();
        test_random_mix(80, 0, 0);
        test_random_mix(80, 81, 0);
        test_random_mix(80, 0, 81);
        test_random_mix(80, 22, 22);
        test_backpressure();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        errors += expected_results.size();
        $display("sent %0d words, checked %0d results: %0d pops, %0d drops, %0d empty answers",
                 words_sent, results_checked, pop_count, drop_count, empty_count);
        $display("covered empty pops, full levels, idle and stall phases, long output hold");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
